### rtl/core/sfdc_pkg.sv
package sfdc_pkg;

  // register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_SPEED_CUTOFF      = 3'd0;
  localparam logic [2:0] REG_TEMP_START        = 3'd1;
  localparam logic [2:0] REG_TEMP_FULL_CLIMATE = 3'd2;
  localparam logic [2:0] REG_TEMP_FULL_NORMAL  = 3'd3;
  localparam logic [2:0] REG_RUNNING_RPM       = 3'd4;
  localparam logic [2:0] REG_CRANK_SECONDS     = 3'd5;
  localparam logic [2:0] REG_RAMP_INTERVAL     = 3'd6;
  localparam logic [2:0] REG_STAGE_THRESHOLD   = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_SPEED_CUTOFF      = 8'd50;
  localparam logic [8:0]  RST_TEMP_START        = 9'd165;
  localparam logic [8:0]  RST_TEMP_FULL_CLIMATE = 9'd185;
  localparam logic [8:0]  RST_TEMP_FULL_NORMAL  = 9'd195;
  localparam logic [13:0] RST_RUNNING_RPM       = 14'd200;
  localparam logic [15:0] RST_CRANK_SECONDS     = 16'd20;
  localparam logic [31:0] RST_RAMP_INTERVAL     = 32'd4000000;
  localparam logic [6:0]  RST_STAGE_THRESHOLD   = 7'd5;

  // duty constants
  localparam logic [6:0] DUTY_FULL      = 7'd100;
  localparam logic [6:0] DUTY_CRANK_CAP = 7'd50;

  // highest quotient bit of the divider (quotient is below 128)
  localparam logic [2:0] DIV_TOP_BIT = 3'd6;

  // sequencer steps
  typedef logic [2:0] step_t;
  localparam step_t STEP_WAIT = 3'd0;
  localparam step_t STEP_PREP = 3'd1;
  localparam step_t STEP_DIV  = 3'd2;
  localparam step_t STEP_QUO  = 3'd3;
  localparam step_t STEP_CAP  = 3'd4;
  localparam step_t STEP_FAN1 = 3'd5;
  localparam step_t STEP_FAN2 = 3'd6;
  localparam step_t STEP_OUT  = 3'd7;

  // datapath operations
  typedef enum logic [2:0] {
    OP_WAIT = 3'd0,
    OP_PREP = 3'd1,
    OP_DIV  = 3'd2,
    OP_QUO  = 3'd3,
    OP_CAP  = 3'd4,
    OP_FAN1 = 3'd5,
    OP_FAN2 = 3'd6,
    OP_OUT  = 3'd7
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_NO_INPUT = 3'd1,
    COND_SKIP_DIV = 3'd2,
    COND_CNT_NZ   = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic skip_div;
    logic cnt_nz;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [7:0]  speed_cutoff;
    logic [8:0]  temp_start;
    logic [8:0]  temp_full_climate;
    logic [8:0]  temp_full_normal;
    logic [13:0] running_rpm;
    logic [15:0] crank_seconds;
    logic [31:0] ramp_interval;
    logic [6:0]  stage_threshold;
  } cfg_t;

endpackage

### rtl/core/sfdc_regs.sv
module sfdc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output sfdc_pkg::cfg_t      cfg_o
);

  sfdc_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_cutoff      <= sfdc_pkg::RST_SPEED_CUTOFF;
      cfg_q.temp_start        <= sfdc_pkg::RST_TEMP_START;
      cfg_q.temp_full_climate <= sfdc_pkg::RST_TEMP_FULL_CLIMATE;
      cfg_q.temp_full_normal  <= sfdc_pkg::RST_TEMP_FULL_NORMAL;
      cfg_q.running_rpm       <= sfdc_pkg::RST_RUNNING_RPM;
      cfg_q.crank_seconds     <= sfdc_pkg::RST_CRANK_SECONDS;
      cfg_q.ramp_interval     <= sfdc_pkg::RST_RAMP_INTERVAL;
      cfg_q.stage_threshold   <= sfdc_pkg::RST_STAGE_THRESHOLD;
    end else if (wr_en) begin
      case (reg_idx)
        sfdc_pkg::REG_SPEED_CUTOFF:      cfg_q.speed_cutoff      <= pwdata[7:0];
        sfdc_pkg::REG_TEMP_START:        cfg_q.temp_start        <= pwdata[8:0];
        sfdc_pkg::REG_TEMP_FULL_CLIMATE: cfg_q.temp_full_climate <= pwdata[8:0];
        sfdc_pkg::REG_TEMP_FULL_NORMAL:  cfg_q.temp_full_normal  <= pwdata[8:0];
        sfdc_pkg::REG_RUNNING_RPM:       cfg_q.running_rpm       <= pwdata[13:0];
        sfdc_pkg::REG_CRANK_SECONDS:     cfg_q.crank_seconds     <= pwdata[15:0];
        sfdc_pkg::REG_RAMP_INTERVAL:     cfg_q.ramp_interval     <= pwdata;
        sfdc_pkg::REG_STAGE_THRESHOLD:   cfg_q.stage_threshold   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      sfdc_pkg::REG_SPEED_CUTOFF:      prdata = {24'd0, cfg_q.speed_cutoff};
      sfdc_pkg::REG_TEMP_START:        prdata = {23'd0, cfg_q.temp_start};
      sfdc_pkg::REG_TEMP_FULL_CLIMATE: prdata = {23'd0, cfg_q.temp_full_climate};
      sfdc_pkg::REG_TEMP_FULL_NORMAL:  prdata = {23'd0, cfg_q.temp_full_normal};
      sfdc_pkg::REG_RUNNING_RPM:       prdata = {18'd0, cfg_q.running_rpm};
      sfdc_pkg::REG_CRANK_SECONDS:     prdata = {16'd0, cfg_q.crank_seconds};
      sfdc_pkg::REG_RAMP_INTERVAL:     prdata = cfg_q.ramp_interval;
      sfdc_pkg::REG_STAGE_THRESHOLD:   prdata = {25'd0, cfg_q.stage_threshold};
      default:                         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/sfdc_seq.sv
module sfdc_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  sfdc_pkg::dp_status_t   status_i,
  output sfdc_pkg::ctrl_word_t   ctrl_o
);

  sfdc_pkg::step_t      pc_q, pc_d;
  sfdc_pkg::ctrl_word_t cw;
  logic                 take_jump;

  // control program, one word per step
  function automatic sfdc_pkg::ctrl_word_t rom_word(input sfdc_pkg::step_t pc);
    sfdc_pkg::ctrl_word_t w;
    begin
      case (pc)
        sfdc_pkg::STEP_WAIT:
          w = '{sfdc_pkg::OP_WAIT, sfdc_pkg::COND_NO_INPUT, sfdc_pkg::STEP_WAIT};
        sfdc_pkg::STEP_PREP:
          w = '{sfdc_pkg::OP_PREP, sfdc_pkg::COND_SKIP_DIV, sfdc_pkg::STEP_CAP};
        sfdc_pkg::STEP_DIV:
          w = '{sfdc_pkg::OP_DIV, sfdc_pkg::COND_CNT_NZ, sfdc_pkg::STEP_DIV};
        sfdc_pkg::STEP_QUO:
          w = '{sfdc_pkg::OP_QUO, sfdc_pkg::COND_NEVER, sfdc_pkg::STEP_WAIT};
        sfdc_pkg::STEP_CAP:
          w = '{sfdc_pkg::OP_CAP, sfdc_pkg::COND_NEVER, sfdc_pkg::STEP_WAIT};
        sfdc_pkg::STEP_FAN1:
          w = '{sfdc_pkg::OP_FAN1, sfdc_pkg::COND_NEVER, sfdc_pkg::STEP_WAIT};
        sfdc_pkg::STEP_FAN2:
          w = '{sfdc_pkg::OP_FAN2, sfdc_pkg::COND_NEVER, sfdc_pkg::STEP_WAIT};
        sfdc_pkg::STEP_OUT:
          w = '{sfdc_pkg::OP_OUT, sfdc_pkg::COND_OUT_BUSY, sfdc_pkg::STEP_OUT};
        default:
          w = '{sfdc_pkg::OP_WAIT, sfdc_pkg::COND_NEVER, sfdc_pkg::STEP_WAIT};
      endcase
      return w;
    end
  endfunction

  assign cw = rom_word(pc_q);

  // jump condition select
  always_comb begin
    case (cw.cond)
      sfdc_pkg::COND_NEVER:    take_jump = 1'b0;
      sfdc_pkg::COND_NO_INPUT: take_jump = ~in_valid_i;
      sfdc_pkg::COND_SKIP_DIV: take_jump = status_i.skip_div;
      sfdc_pkg::COND_CNT_NZ:   take_jump = status_i.cnt_nz;
      sfdc_pkg::COND_OUT_BUSY: take_jump = status_i.out_busy;
      default:                 take_jump = 1'b0;
    endcase
  end

  // step counter, the last step falls through to the wait step
  assign pc_d = take_jump ? cw.target : sfdc_pkg::step_t'(pc_q + 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sfdc_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = cw;

endmodule

### rtl/core/sfdc_dp.sv
module sfdc_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfdc_pkg::ctrl_word_t   ctrl_i,
  input  sfdc_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  input  logic [31:0]            now_time_i,
  input  logic [7:0]             speed_mph_i,
  input  logic [8:0]             radiator_temp_i,
  input  logic                   climate_on_i,
  input  logic [13:0]            engine_rpm_i,
  input  logic [15:0]            run_seconds_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [6:0]             first_fan_duty_o,
  output logic [6:0]             second_fan_duty_o,
  output sfdc_pkg::dp_status_t   status_o
);

  // captured beat
  logic [31:0] now_q;
  logic [7:0]  spd_q;
  logic [8:0]  temp_q;
  logic        clim_q;
  logic [13:0] rpm_q;
  logic [15:0] secs_q;

  // divider and target
  logic [15:0] rem_q;
  logic [8:0]  dvs_q;
  logic [6:0]  quo_q;
  logic [2:0]  cnt_q;
  logic [6:0]  target_q;

  // fan state
  logic [6:0]  lvl1_q, lvl2_q;
  logic [31:0] stamp1_q, stamp2_q;
  logic        fan2_en_q;

  // output register
  logic        out_valid_q;
  logic [6:0]  out1_q, out2_q;

  logic        capture;
  logic        out_free;
  logic [8:0]  full_w;
  logic        gate;
  logic        above;
  logic        at_full;
  logic        skip_div;
  logic [6:0]  prep_target;
  logic [8:0]  diff;
  logic [15:0] num;
  logic [15:0] shifted;
  logic        div_ge;
  logic        running;
  logic [6:0]  capped;
  logic [6:0]  cur_lvl;
  logic [31:0] cur_stamp;
  logic [31:0] elapsed;
  logic [6:0]  nxt_lvl;
  logic        changed;
  logic        step_up;

  assign capture  = (ctrl_i.op == sfdc_pkg::OP_WAIT) & in_valid_i;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // target bounds
  assign full_w      = clim_q ? cfg_i.temp_full_climate : cfg_i.temp_full_normal;
  assign gate        = (spd_q < cfg_i.speed_cutoff) & (temp_q >= cfg_i.temp_start);
  assign above       = temp_q > cfg_i.temp_start;
  assign at_full     = temp_q >= full_w;
  assign skip_div    = ~gate | ~above | at_full;
  assign prep_target = (gate & above & at_full) ? sfdc_pkg::DUTY_FULL : 7'd0;
  assign diff        = temp_q - cfg_i.temp_start;
  assign num         = 16'(diff) * 16'(sfdc_pkg::DUTY_FULL);

  // restoring divide, one quotient bit per step
  assign shifted = {7'd0, dvs_q} << cnt_q;
  assign div_ge  = rem_q >= shifted;

  // engine cranking cap
  assign running = rpm_q > cfg_i.running_rpm;
  always_comb begin
    if (running) begin
      capped = target_q;
    end else if (secs_q < cfg_i.crank_seconds) begin
      capped = (target_q > sfdc_pkg::DUTY_CRANK_CAP) ? sfdc_pkg::DUTY_CRANK_CAP : target_q;
    end else begin
      capped = 7'd0;
    end
  end

  // shared ramp unit for both fans
  assign cur_lvl   = (ctrl_i.op == sfdc_pkg::OP_FAN2) ? lvl2_q : lvl1_q;
  assign cur_stamp = (ctrl_i.op == sfdc_pkg::OP_FAN2) ? stamp2_q : stamp1_q;
  assign elapsed   = now_q - cur_stamp;
  always_comb begin
    if (target_q <= cur_lvl) begin
      nxt_lvl = target_q;
    end else if (elapsed >= cfg_i.ramp_interval) begin
      nxt_lvl = cur_lvl + 7'd1;
    end else begin
      nxt_lvl = cur_lvl;
    end
  end
  assign changed = nxt_lvl != cur_lvl;
  assign step_up = nxt_lvl > cur_lvl;

  // beat capture and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      now_q  <= now_time_i;
      spd_q  <= speed_mph_i;
      temp_q <= radiator_temp_i;
      clim_q <= climate_on_i;
      rpm_q  <= engine_rpm_i;
      secs_q <= run_seconds_i;
    end
    case (ctrl_i.op)
      sfdc_pkg::OP_PREP: begin
        target_q <= prep_target;
        rem_q    <= num;
        dvs_q    <= full_w - cfg_i.temp_start;
        quo_q    <= 7'd0;
        cnt_q    <= sfdc_pkg::DIV_TOP_BIT;
      end
      sfdc_pkg::OP_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - shifted;
        end
        quo_q <= {quo_q[5:0], div_ge};
        cnt_q <= cnt_q - 3'd1;
      end
      sfdc_pkg::OP_QUO: begin
        target_q <= quo_q;
      end
      sfdc_pkg::OP_CAP: begin
        target_q <= capped;
      end
      default: ;
    endcase
  end

  // fan levels and change stamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl1_q    <= 7'd0;
      lvl2_q    <= 7'd0;
      stamp1_q  <= 32'd0;
      stamp2_q  <= 32'd0;
      fan2_en_q <= 1'b0;
    end else begin
      case (ctrl_i.op)
        sfdc_pkg::OP_FAN1: begin
          if (changed) begin
            lvl1_q   <= nxt_lvl;
            stamp1_q <= now_q;
          end
          // fan one moves down or by one step up; only an upward step
          // can exceed the threshold, and only a zero threshold
          fan2_en_q <= ~(step_up & (cfg_i.stage_threshold == 7'd0));
        end
        sfdc_pkg::OP_FAN2: begin
          if (fan2_en_q & changed) begin
            lvl2_q   <= nxt_lvl;
            stamp2_q <= now_q;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.op == sfdc_pkg::OP_OUT) & out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q & ~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.op == sfdc_pkg::OP_OUT) & out_free) begin
      out1_q <= lvl1_q;
      out2_q <= lvl2_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign first_fan_duty_o  = out1_q;
  assign second_fan_duty_o = out2_q;

  assign status_o.skip_div = skip_div;
  assign status_o.cnt_nz   = cnt_q != 3'd0;
  assign status_o.out_busy = ~out_free;

endmodule

### rtl/core/staged_fan_duty_controller_top.sv
// each input beat runs prep, divide, quotient, cap, both fan steps and output;
//   fixed duties of 0 or 100 go from prep to cap (7-step divider skipped)
// beats pass the microcode sequence and serial divider one at a time, as input
//   is taken only in the wait step; a stalled result holds the last step
// reset: registers return to defaults, fan levels and stamps clear, no result pending
module staged_fan_duty_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_time_i,
  input  logic [7:0]  speed_mph_i,
  input  logic [8:0]  radiator_temp_i,
  input  logic        climate_on_i,
  input  logic [13:0] engine_rpm_i,
  input  logic [15:0] run_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  first_fan_duty_o,
  output logic [6:0]  second_fan_duty_o
);

  sfdc_pkg::cfg_t       cfg;
  sfdc_pkg::ctrl_word_t ctrl;
  sfdc_pkg::dp_status_t status;

  assign pready = 1'b1;

  // configuration registers
  sfdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // microcode sequencer
  sfdc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // datapath
  sfdc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .now_time_i        (now_time_i),
    .speed_mph_i       (speed_mph_i),
    .radiator_temp_i   (radiator_temp_i),
    .climate_on_i      (climate_on_i),
    .engine_rpm_i      (engine_rpm_i),
    .run_seconds_i     (run_seconds_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .first_fan_duty_o  (first_fan_duty_o),
    .second_fan_duty_o (second_fan_duty_o),
    .status_o          (status)
  );

  // input taken only in the wait step
  assign in_stall_o = ctrl.op != sfdc_pkg::OP_WAIT;

endmodule

### rtl/core/sfdc_checker.sv
module sfdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] first_fan_duty_o,
  input logic [6:0] second_fan_duty_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_fan_duty_o)
      && $stable(second_fan_duty_o))
    else $error("stalled result changed");

  // duties stay within percent range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> first_fan_duty_o <= 7'd100 && second_fan_duty_o <= 7'd100)
    else $error("duty above 100");

  // an accepted beat keeps the input side busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // a new result only appears out of a busy sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in flight");

endmodule

bind staged_fan_duty_controller_top sfdc_checker u_sfdc_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfdc_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int RUN_LIMIT = 300000;
  localparam int MAX_WAIT  = 10;

  typedef struct {
    logic [31:0] now;
    logic [7:0]  speed;
    logic [8:0]  temp;
    logic        climate;
    logic [13:0] rpm;
    logic [15:0] secs;
  } fan_tick_t;

  typedef struct {
    logic [6:0] fan1;
    logic [6:0] fan2;
  } duty_pair_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [31:0] now_time_i      = '0;
  logic [7:0]  speed_mph_i     = '0;
  logic [8:0]  radiator_temp_i = '0;
  logic        climate_on_i    = 1'b0;
  logic [13:0] engine_rpm_i    = '0;
  logic [15:0] run_seconds_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [6:0]  first_fan_duty_o;
  logic [6:0]  second_fan_duty_o;

  // shadow of the block: settings and fan state
  cfg_t        cfg_now;
  logic [6:0]  fan1_level;
  logic [31:0] fan1_stamp;
  logic [6:0]  fan2_level;
  logic [31:0] fan2_stamp;
  duty_pair_t  duty_expect_q[$];

  // traffic shaping
  logic [31:0] sim_clock;
  int          sim_temp;
  logic        sim_climate;
  bit          no_idle;

  int          fail_count  = 0;
  int          cycle_count = 0;
  int          result_hold = 0;
  duty_pair_t  want;

  staged_fan_duty_controller_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_time_i        (now_time_i),
    .speed_mph_i       (speed_mph_i),
    .radiator_temp_i   (radiator_temp_i),
    .climate_on_i      (climate_on_i),
    .engine_rpm_i      (engine_rpm_i),
    .run_seconds_i     (run_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .first_fan_duty_o  (first_fan_duty_o),
    .second_fan_duty_o (second_fan_duty_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL staged_fan_duty_controller_top");
      $finish;
    end
  end

  // target duty from speed, temperature, climate and engine state
  function automatic logic [6:0] target_percent(input fan_tick_t t);
    logic [8:0]  full;
    int unsigned quot;
    logic [6:0]  duty;
    if (!(t.speed < cfg_now.speed_cutoff && t.temp >= cfg_now.temp_start)) return '0;
    full = t.climate ? cfg_now.temp_full_climate : cfg_now.temp_full_normal;
    if (t.temp <= cfg_now.temp_start) begin
      duty = '0;
    end else if (t.temp >= full) begin
      duty = DUTY_FULL;
    end else begin
      quot = (int'(DUTY_FULL) * (int'(t.temp) - int'(cfg_now.temp_start)))
             / (int'(full) - int'(cfg_now.temp_start));
      duty = quot[6:0];
    end
    // engine stopped: capped while cranking, off afterwards
    if (!(t.rpm > cfg_now.running_rpm)) begin
      if (t.secs < cfg_now.crank_seconds) begin
        if (duty > DUTY_CRANK_CAP) duty = DUTY_CRANK_CAP;
      end else begin
        duty = '0;
      end
    end
    return duty;
  endfunction

  // move one fan toward the target, return its signed change
  function automatic int step_fan(inout logic [6:0] level, inout logic [31:0] stamp,
                                  input logic [31:0] now, input logic [6:0] target);
    logic [6:0]  next_level;
    logic [31:0] elapsed;
    int          change;
    elapsed = now - stamp;
    if (target <= level) begin
      next_level = target;
    end else if (elapsed >= cfg_now.ramp_interval) begin
      next_level = level + 7'd1;
    end else begin
      return 0;
    end
    if (next_level == level) return 0;
    change = int'(next_level) - int'(level);
    stamp  = now;
    level  = next_level;
    return change;
  endfunction

  function automatic duty_pair_t predict_duties(input fan_tick_t t);
    logic [6:0] target;
    int         change;
    duty_pair_t duties;
    target = target_percent(t);
    change = step_fan(fan1_level, fan1_stamp, t.now, target);
    // second fan only follows while the first one is not stepping hard
    if (change <= int'(cfg_now.stage_threshold))
      void'(step_fan(fan2_level, fan2_stamp, t.now, target));
    duties.fan1 = fan1_level;
    duties.fan2 = fan2_level;
    return duties;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic fan_tick_t make_tick(input logic [31:0] now, input logic [7:0] speed,
                                          input logic [8:0] temp, input logic climate,
                                          input logic [13:0] rpm, input logic [15:0] secs);
    fan_tick_t t;
    t.now     = now;
    t.speed   = speed;
    t.temp    = temp;
    t.climate = climate;
    t.rpm     = rpm;
    t.secs    = secs;
    return t;
  endfunction

  // one input beat; valid stays high so a following beat can go back to back
  task automatic send_tick(input fan_tick_t t);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    now_time_i      <= t.now;
    speed_mph_i     <= t.speed;
    radiator_temp_i <= t.temp;
    climate_on_i    <= t.climate;
    engine_rpm_i    <= t.rpm;
    run_seconds_i   <= t.secs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    duty_expect_q.push_back(predict_duties(t));
  endtask

  // stop sending and let every pending result come out
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup and access cycle, register written at the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPEED_CUTOFF:      cfg_now.speed_cutoff      = value[7:0];
      REG_TEMP_START:        cfg_now.temp_start        = value[8:0];
      REG_TEMP_FULL_CLIMATE: cfg_now.temp_full_climate = value[8:0];
      REG_TEMP_FULL_NORMAL:  cfg_now.temp_full_normal  = value[8:0];
      REG_RUNNING_RPM:       cfg_now.running_rpm       = value[13:0];
      REG_CRANK_SECONDS:     cfg_now.crank_seconds     = value[15:0];
      REG_RAMP_INTERVAL:     cfg_now.ramp_interval     = value;
      REG_STAGE_THRESHOLD:   cfg_now.stage_threshold   = value[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // mode 0 gives zero, mode 1 the all-ones value, anything else a working value
  function automatic logic [31:0] pick_reg(input logic [2:0] idx, input int mode);
    logic [31:0] top;
    int          f;
    case (idx)
      REG_SPEED_CUTOFF:    top = 32'hFF;
      REG_RUNNING_RPM:     top = 32'h3FFF;
      REG_CRANK_SECONDS:   top = 32'hFFFF;
      REG_RAMP_INTERVAL:   top = 32'hFFFF_FFFF;
      REG_STAGE_THRESHOLD: top = 32'h7F;
      default:             top = 32'h1FF;
    endcase
    if (mode == 0) return '0;
    if (mode == 1) return top;
    case (idx)
      REG_SPEED_CUTOFF: return $urandom_range(20, 255);
      REG_TEMP_START:   return $urandom_range(60, 400);
      REG_TEMP_FULL_CLIMATE, REG_TEMP_FULL_NORMAL: begin
        // mostly above the start point, sometimes at or below it
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, cfg_now.temp_start);
        f = int'(cfg_now.temp_start) + int'($urandom_range(1, 80));
        return (f > 511) ? 32'd511 : 32'(f);
      end
      REG_RUNNING_RPM:   return $urandom_range(0, 3000);
      REG_CRANK_SECONDS: return $urandom_range(0, 120);
      REG_RAMP_INTERVAL: begin
        if ($urandom_range(0, 7) == 0) return $urandom();
        if ($urandom_range(0, 7) == 0) return RST_RAMP_INTERVAL;
        return $urandom_range(0, 2000);
      end
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 10);
    endcase
  endfunction

  // next control tick: time near the ramp interval, temperature drifting upward
  function automatic fan_tick_t next_tick();
    fan_tick_t t;
    int        roll;
    int        lo;
    int        hi;
    roll = $urandom_range(0, 19);
    if (roll == 0) sim_clock = $urandom();
    else if (roll < 5) sim_clock = sim_clock + $urandom_range(0, cfg_now.ramp_interval);
    else sim_clock = sim_clock + cfg_now.ramp_interval + $urandom_range(0, 3);

    lo = int'(cfg_now.temp_start) - 10;
    hi = int'(cfg_now.temp_start);
    if (int'(cfg_now.temp_full_climate) > hi) hi = int'(cfg_now.temp_full_climate);
    if (int'(cfg_now.temp_full_normal) > hi) hi = int'(cfg_now.temp_full_normal);
    hi = hi + 10;
    if (lo < 0) lo = 0;
    if (hi > 511) hi = 511;
    if ($urandom_range(0, 9) == 0) begin
      sim_temp = $urandom_range(0, 511);
    end else begin
      sim_temp = sim_temp + int'($urandom_range(0, 7)) - 3;
      if (sim_temp < lo) sim_temp = lo;
      if (sim_temp > hi) sim_temp = hi;
    end
    if ($urandom_range(0, 19) == 0) sim_climate = ~sim_climate;

    t.now     = sim_clock;
    t.temp    = 9'(sim_temp);
    t.climate = sim_climate;
    if (cfg_now.speed_cutoff == 0 || $urandom_range(0, 4) == 0)
      t.speed = 8'($urandom_range(0, 255));
    else
      t.speed = 8'($urandom_range(0, int'(cfg_now.speed_cutoff) - 1));
    if (cfg_now.running_rpm == 14'h3FFF || $urandom_range(0, 5) == 0)
      t.rpm = 14'($urandom_range(0, 16383));
    else
      t.rpm = 14'($urandom_range(int'(cfg_now.running_rpm) + 1, 16383));
    if ($urandom_range(0, 1) == 0)
      t.secs = 16'($urandom_range(0, 65535));
    else
      t.secs = 16'($urandom_range(0, 2 * int'(cfg_now.crank_seconds) + 1));
    return t;
  endfunction

  // result side: random stall per beat, compare with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (duty_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got fan1=%0d fan2=%0d",
                   $time, first_fan_duty_o, second_fan_duty_o);
          fail_count++;
        end else begin
          want = duty_expect_q.pop_front();
          if (first_fan_duty_o !== want.fan1) begin
            $display("%0t: first_fan_duty expected %0d got %0d",
                     $time, want.fan1, first_fan_duty_o);
            fail_count++;
          end
          if (second_fan_duty_o !== want.fan2) begin
            $display("%0t: second_fan_duty expected %0d got %0d",
                     $time, want.fan2, second_fan_duty_o);
            fail_count++;
          end
        end
        result_hold = draw_wait();
      end
      if (result_hold > 0) begin
        out_stall_i <= 1'b1;
        result_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // default settings: ramp timing, cutoffs, cranking, interpolation, time wrap
  task automatic test_default_ramp();
    send_tick(make_tick(32'd0,        8'd0,   9'd511, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'd4000000,  8'd0,   9'd511, 1'b0, 14'd16383, 16'd65535));
    send_tick(make_tick(32'd7999999,  8'd0,   9'd511, 1'b1, 14'd16383, 16'd0));
    send_tick(make_tick(32'd8000000,  8'd0,   9'd511, 1'b1, 14'd16383, 16'd0));
    send_tick(make_tick(32'd12000000, 8'd49,  9'd175, 1'b1, 14'd16383, 16'd0));
    send_tick(make_tick(32'd12000001, 8'd50,  9'd511, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'd12000002, 8'd255, 9'd0,   1'b0, 14'd0,     16'd0));
    send_tick(make_tick(32'd16000000, 8'd0,   9'd511, 1'b0, 14'd200,   16'd19));
    send_tick(make_tick(32'd20000000, 8'd0,   9'd511, 1'b0, 14'd200,   16'd19));
    send_tick(make_tick(32'd20000001, 8'd0,   9'd511, 1'b0, 14'd0,     16'd20));
    send_tick(make_tick(32'd24000001, 8'd0,   9'd166, 1'b0, 14'd201,   16'd65535));
    send_tick(make_tick(32'd28000001, 8'd0,   9'd165, 1'b0, 14'd201,   16'd0));
    send_tick(make_tick(32'd28000002, 8'd0,   9'd164, 1'b1, 14'd201,   16'd0));
    send_tick(make_tick(32'hFFFF_FFF0, 8'd0,  9'd195, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'h0030_0000, 8'd0,  9'd195, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'h003D_0900, 8'd0,  9'd195, 1'b0, 14'd16383, 16'd0));
  endtask

  // zero interval, full point at or below start, stage threshold limits
  task automatic test_special_settings();
    drain_block();
    write_reg(REG_RAMP_INTERVAL, 32'd0);
    write_reg(REG_STAGE_THRESHOLD, 32'd0);
    write_reg(REG_TEMP_FULL_NORMAL, 32'd165);
    send_tick(make_tick(32'd100, 8'd0, 9'd166, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'd100, 8'd0, 9'd166, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'd101, 8'd0, 9'd166, 1'b0, 14'd16383, 16'd0));
    send_tick(make_tick(32'd102, 8'd0, 9'd165, 1'b0, 14'd16383, 16'd0));
    drain_block();
    write_reg(REG_TEMP_FULL_CLIMATE, 32'd0);
    write_reg(REG_STAGE_THRESHOLD, 32'd127);
    send_tick(make_tick(32'd200, 8'd0, 9'd200, 1'b1, 14'd16383, 16'd0));
    send_tick(make_tick(32'd200, 8'd0, 9'd200, 1'b1, 14'd16383, 16'd0));
    drain_block();
    write_reg(REG_SPEED_CUTOFF, 32'd0);
    send_tick(make_tick(32'd300, 8'd0, 9'd200, 1'b1, 14'd16383, 16'd0));
  endtask

  // random settings per phase, extremes first, then random tick streams
  task automatic test_mixed_settings();
    int mode;
    for (int p = 0; p < 10; p++) begin
      drain_block();
      for (int r = 0; r < 8; r++) begin
        mode = (p < 2) ? p : $urandom_range(0, 7);
        write_reg(3'(r), pick_reg(3'(r), mode));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ((p < 2) ? 40 : 103); n++) send_tick(next_tick());
    end
  endtask

  initial begin
    cfg_now.speed_cutoff      = RST_SPEED_CUTOFF;
    cfg_now.temp_start        = RST_TEMP_START;
    cfg_now.temp_full_climate = RST_TEMP_FULL_CLIMATE;
    cfg_now.temp_full_normal  = RST_TEMP_FULL_NORMAL;
    cfg_now.running_rpm       = RST_RUNNING_RPM;
    cfg_now.crank_seconds     = RST_CRANK_SECONDS;
    cfg_now.ramp_interval     = RST_RAMP_INTERVAL;
    cfg_now.stage_threshold   = RST_STAGE_THRESHOLD;
    fan1_level  = '0;
    fan1_stamp  = '0;
    fan2_level  = '0;
    fan2_stamp  = '0;
    sim_clock   = '0;
    sim_temp    = 165;
    sim_climate = 1'b0;
    no_idle     = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_ramp();
    test_special_settings();
    test_mixed_settings();

    drain_block();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS staged_fan_duty_controller_top");
    end else begin
      $display("FAIL staged_fan_duty_controller_top");
    end
    $finish;
  end

endmodule
